FILE: src/wheel_speed_pi_loop_defines.svh
// Assertion helpers shared by the checker files.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef WHEEL_SPEED_PI_LOOP_DEFINES_SVH
`define WHEEL_SPEED_PI_LOOP_DEFINES_SVH

// same-cycle implication
`define WSPL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wspl check failed: same-cycle implication");

// next-cycle implication
`define WSPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wspl check failed: next-cycle implication");

`endif

FILE: src/wspl_pkg.sv
`default_nettype none

package wspl_pkg;

    // payload widths
    localparam int PULSE_W    = 16;
    localparam int TARGET_W   = 21;
    localparam int DRIVE_W    = 17;
    localparam int SPEED_W    = 23;  // rpm and target pulses, Q.8
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int WC_W       = 18;
    localparam int LIM_W      = 16;

    // fixed-point scaling
    localparam int FRAC_Q    = 8;
    localparam int FRAC_GAIN = 16;
    localparam int FRAC_PPR  = 24;
    localparam int DEADBAND  = 256;  // 1.0 in Q.8

    localparam logic [WC_W-1:0] WHEEL_CORR_RESET = 18'd65536;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_CORR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSES_RPM    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd6;

    typedef enum logic [2:0] {
        MSEL_RPM,
        MSEL_TP,
        MSEL_INT,
        MSEL_PROP,
        MSEL_DERIV
    } msel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MUL_RPM,
        ST_MUL_TP,
        ST_FILT,
        ST_ERR,
        ST_MUL_INT,
        ST_MUL_PROP,
        ST_MUL_DERIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic  load_in;
        logic  clear_state;
        logic  mul_start;
        msel_t mul_sel;
        logic  filt_step;
        logic  err_step;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
    } stat_t;

endpackage

`default_nettype wire

FILE: src/wspl_if.sv
`default_nettype none

interface wspl_in_if;
    import wspl_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [PULSE_W-1:0]  pulse_count;
    logic signed [TARGET_W-1:0] target_speed;
    logic                       clear_history;

    modport source (output valid, output pulse_count, output target_speed,
                    output clear_history, input ready);
    modport sink   (input valid, input pulse_count, input target_speed,
                    input clear_history, output ready);
endinterface

interface wspl_out_if;
    import wspl_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive_value;
    logic                      drive_clamped;

    modport source (output valid, output drive_value, output drive_clamped,
                    input ready);
    modport sink   (input valid, input drive_value, input drive_clamped,
                    output ready);
endinterface

interface wspl_cfg_if;
    import wspl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/wspl_mul.sv
`default_nettype none

// Signed A times unsigned B, two digits of B per product, high digit first.
module wspl_mul #(
    parameter int A_WIDTH = 33,
    parameter int B_WIDTH = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [A_WIDTH-1:0]          a,
    input  logic        [B_WIDTH-1:0]          b,
    output logic                               done,
    output logic signed [A_WIDTH+B_WIDTH-1:0]  product
);
    localparam int DIG_W  = B_WIDTH / 2;
    localparam int PW     = A_WIDTH + B_WIDTH;
    localparam int PART_W = A_WIDTH + DIG_W + 1;

    logic                      phase_reg;
    logic                      done_reg;
    logic signed [A_WIDTH-1:0] a_reg;
    logic [DIG_W-1:0]          blo_reg;
    logic signed [PW-1:0]      acc_reg;
    logic signed [PW-1:0]      acc_next;

    logic signed [A_WIDTH-1:0] a_sel;
    logic [DIG_W-1:0]          digit;
    logic signed [PART_W-1:0]  partial;

    assign a_sel   = start ? a : a_reg;
    assign digit   = start ? b[B_WIDTH-1:DIG_W] : blo_reg;
    assign partial = a_sel * $signed({1'b0, digit});

    always_comb
    begin
        if (start)
        begin
            acc_next = PW'(partial);
        end
        else
        begin
            acc_next = (acc_reg <<< DIG_W) + PW'(partial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= start;
            done_reg  <= phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            blo_reg <= b[DIG_W-1:0];
        end
        if (start || phase_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

FILE: src/wspl_dp.sv
`default_nettype none

module wspl_dp #(
    parameter int STATE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wspl_pkg::cmd_t                      cmd,
    output wspl_pkg::stat_t                     stat,
    input  logic                                cfg_write,
    input  logic [wspl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wspl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [wspl_pkg::PULSE_W-1:0] pulse_count,
    input  logic signed [wspl_pkg::TARGET_W-1:0] target_speed,
    output logic signed [wspl_pkg::DRIVE_W-1:0] drive_value,
    output logic                                drive_clamped
);
    import wspl_pkg::*;

    localparam int SW   = STATE_WIDTH;
    localparam int AW   = SW + 1;
    localparam int BW   = CFG_DATA_W;
    localparam int PW   = AW + BW;
    localparam int ACCW = PW + 2;

    localparam logic signed [PW-1:0] SAT_HI = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_LO = {{(PW-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] ST_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] ST_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] DB_POS = SW'(DEADBAND);

    // configuration
    logic [BW-1:0]    gp_reg, gi_reg, gd_reg, ppr_reg;
    logic [WC_W-1:0]  wc_reg;
    logic [LIM_W-1:0] ilim_reg, dlim_reg;

    // controller state
    logic signed [SW-1:0] integ_reg, filt_reg, prev_reg;

    // working values
    logic signed [PULSE_W-1:0]  count_reg;
    logic signed [TARGET_W-1:0] target_reg;
    logic signed [SPEED_W-1:0]  rpm_reg, tp_reg;
    logic signed [SW-1:0]       err_reg;
    logic signed [ACCW-1:0]     acc_reg;
    logic signed [DRIVE_W-1:0]  drive_value_reg;
    logic                       drive_clamped_reg;

    // multiplier
    logic signed [AW-1:0] mul_a;
    logic [BW-1:0]        mul_b;
    logic                 mul_done;
    logic signed [PW-1:0] prod;

    always_comb
    begin
        case (cmd.mul_sel)
            MSEL_RPM:
            begin
                mul_a = AW'(target_reg);
                mul_b = BW'(wc_reg);
            end
            MSEL_TP:
            begin
                mul_a = AW'(rpm_reg);
                mul_b = ppr_reg;
            end
            MSEL_INT:
            begin
                mul_a = AW'(err_reg);
                mul_b = gi_reg;
            end
            MSEL_PROP:
            begin
                mul_a = AW'(err_reg);
                mul_b = gp_reg;
            end
            MSEL_DERIV:
            begin
                mul_a = AW'(err_reg) - AW'(prev_reg);
                mul_b = gd_reg;
            end
            default:
            begin
                mul_a = AW'(target_reg);
                mul_b = BW'(wc_reg);
            end
        endcase
    end

    wspl_mul #(
        .A_WIDTH (AW),
        .B_WIDTH (BW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (prod)
    );

    assign stat.mul_done = mul_done;

    // truncation toward zero: bias negative values by 2^n - 1 before the shift
    logic signed [PW-1:0] bias16, bias24, quot16, quot24;
    assign bias16 = {{(PW-FRAC_GAIN){1'b0}}, {FRAC_GAIN{prod[PW-1]}}};
    assign bias24 = {{(PW-FRAC_PPR){1'b0}}, {FRAC_PPR{prod[PW-1]}}};
    assign quot16 = (prod + bias16) >>> FRAC_GAIN;
    assign quot24 = (prod + bias24) >>> FRAC_PPR;

    // integral update with deadband, symmetric clamp, then state saturation
    logic signed [PW-1:0] int_sum, int_lim, int_clamp, int_sat;
    logic                 outside_db;
    assign outside_db = (err_reg > DB_POS) || (err_reg < -DB_POS);
    assign int_sum    = PW'(integ_reg) + quot16;
    assign int_lim    = $signed({{(PW-LIM_W-FRAC_Q){1'b0}}, ilim_reg, {FRAC_Q{1'b0}}});

    always_comb
    begin
        if (int_sum > int_lim)
        begin
            int_clamp = int_lim;
        end
        else if (int_sum < -int_lim)
        begin
            int_clamp = -int_lim;
        end
        else
        begin
            int_clamp = int_sum;
        end
        if (int_clamp > SAT_HI)
        begin
            int_sat = SAT_HI;
        end
        else if (int_clamp < SAT_LO)
        begin
            int_sat = SAT_LO;
        end
        else
        begin
            int_sat = int_clamp;
        end
    end

    // half-and-half filter; result always fits the state width
    logic signed [SW:0] count_q8, filt_sum, filt_half;
    assign count_q8  = (SW+1)'($signed({count_reg, {FRAC_Q{1'b0}}}));
    assign filt_sum  = count_q8 + (SW+1)'(filt_reg);
    assign filt_half = (filt_sum + $signed({{SW{1'b0}}, filt_sum[SW]})) >>> 1;

    // error, saturated on signed overflow of the state width
    logic signed [SW:0]   err_diff;
    logic signed [SW-1:0] err_sat;
    assign err_diff = (SW+1)'(tp_reg) - (SW+1)'(filt_reg);

    always_comb
    begin
        if (err_diff[SW] != err_diff[SW-1])
        begin
            err_sat = err_diff[SW] ? ST_MIN : ST_MAX;
        end
        else
        begin
            err_sat = err_diff[SW-1:0];
        end
    end

    // drive: truncate Q.24 sum toward zero, clamp to the drive limit
    logic signed [ACCW-1:0]    acc_bias, drv_full, drv_lim;
    logic                      drv_over, drv_under;
    logic signed [DRIVE_W-1:0] drv_value;
    assign acc_bias  = {{(ACCW-FRAC_PPR){1'b0}}, {FRAC_PPR{acc_reg[ACCW-1]}}};
    assign drv_full  = (acc_reg + acc_bias) >>> FRAC_PPR;
    assign drv_lim   = $signed({{(ACCW-LIM_W){1'b0}}, dlim_reg});
    assign drv_over  = drv_full > drv_lim;
    assign drv_under = drv_full < -drv_lim;

    always_comb
    begin
        if (drv_over)
        begin
            drv_value = drv_lim[DRIVE_W-1:0];
        end
        else if (drv_under)
        begin
            drv_value = -drv_lim[DRIVE_W-1:0];
        end
        else
        begin
            drv_value = drv_full[DRIVE_W-1:0];
        end
    end

    // configuration and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_reg    <= '0;
            gi_reg    <= '0;
            gd_reg    <= '0;
            wc_reg    <= WHEEL_CORR_RESET;
            ppr_reg   <= '0;
            ilim_reg  <= '0;
            dlim_reg  <= '0;
            integ_reg <= '0;
            filt_reg  <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_GAIN_PROP:   gp_reg   <= cfg_data;
                    REG_GAIN_INTEG:  gi_reg   <= cfg_data;
                    REG_GAIN_DERIV:  gd_reg   <= cfg_data;
                    REG_WHEEL_CORR:  wc_reg   <= cfg_data[WC_W-1:0];
                    REG_PULSES_RPM:  ppr_reg  <= cfg_data;
                    REG_INTEG_LIMIT: ilim_reg <= cfg_data[LIM_W-1:0];
                    REG_DRIVE_LIMIT: dlim_reg <= cfg_data[LIM_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.clear_state)
            begin
                integ_reg <= '0;
                filt_reg  <= '0;
                prev_reg  <= '0;
            end
            else
            begin
                if (cmd.filt_step)
                begin
                    filt_reg <= filt_half[SW-1:0];
                end
                if (mul_done && (cmd.mul_sel == MSEL_INT) && outside_db)
                begin
                    integ_reg <= int_sat[SW-1:0];
                end
                if (mul_done && (cmd.mul_sel == MSEL_DERIV))
                begin
                    prev_reg <= err_reg;
                end
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            count_reg  <= pulse_count;
            target_reg <= target_speed;
        end
        if (mul_done && (cmd.mul_sel == MSEL_RPM))
        begin
            rpm_reg <= $signed(quot16[SPEED_W-1:0]);
        end
        if (mul_done && (cmd.mul_sel == MSEL_TP))
        begin
            tp_reg <= $signed(quot24[SPEED_W-1:0]);
        end
        if (cmd.err_step)
        begin
            err_reg <= err_sat;
        end
        if (mul_done && (cmd.mul_sel == MSEL_PROP))
        begin
            acc_reg <= ACCW'(prod) + (ACCW'(integ_reg) <<< FRAC_GAIN);
        end
        if (mul_done && (cmd.mul_sel == MSEL_DERIV))
        begin
            acc_reg <= acc_reg + ACCW'(prod);
        end
        if (cmd.clear_state)
        begin
            drive_value_reg   <= '0;
            drive_clamped_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            drive_value_reg   <= drv_value;
            drive_clamped_reg <= drv_over || drv_under;
        end
    end

    assign drive_value   = drive_value_reg;
    assign drive_clamped = drive_clamped_reg;

endmodule

`default_nettype wire

FILE: src/wspl_ctrl.sv
`default_nettype none

module wspl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_clear,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output wspl_pkg::cmd_t  cmd,
    input  wspl_pkg::stat_t stat
);
    import wspl_pkg::*;

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   mul_state;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_clear ? ST_CLEAR : ST_MUL_RPM;
                end
            end
            ST_CLEAR:     if (out_free)      state_next = ST_IDLE;
            ST_MUL_RPM:   if (stat.mul_done) state_next = ST_MUL_TP;
            ST_MUL_TP:    if (stat.mul_done) state_next = ST_FILT;
            ST_FILT:                         state_next = ST_ERR;
            ST_ERR:                          state_next = ST_MUL_INT;
            ST_MUL_INT:   if (stat.mul_done) state_next = ST_MUL_PROP;
            ST_MUL_PROP:  if (stat.mul_done) state_next = ST_MUL_DERIV;
            ST_MUL_DERIV: if (stat.mul_done) state_next = ST_OUT;
            ST_OUT:       if (out_free)      state_next = ST_IDLE;
            default:                         state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MSEL_RPM;
        mul_state   = 1'b0;
        case (state_reg)
            ST_IDLE:      cmd.load_in     = in_valid;
            ST_CLEAR:     cmd.clear_state = out_free;
            ST_MUL_RPM:
            begin
                mul_state   = 1'b1;
                cmd.mul_sel = MSEL_RPM;
            end
            ST_MUL_TP:
            begin
                mul_state   = 1'b1;
                cmd.mul_sel = MSEL_TP;
            end
            ST_FILT:      cmd.filt_step   = 1'b1;
            ST_ERR:       cmd.err_step    = 1'b1;
            ST_MUL_INT:
            begin
                mul_state   = 1'b1;
                cmd.mul_sel = MSEL_INT;
            end
            ST_MUL_PROP:
            begin
                mul_state   = 1'b1;
                cmd.mul_sel = MSEL_PROP;
            end
            ST_MUL_DERIV:
            begin
                mul_state   = 1'b1;
                cmd.mul_sel = MSEL_DERIV;
            end
            ST_OUT:       cmd.out_load    = out_free;
            default:      ;
        endcase
        cmd.mul_start = mul_state && !issued_reg;

        issued_next = issued_reg;
        if (cmd.mul_start)
        begin
            issued_next = 1'b1;
        end
        else if (stat.mul_done)
        begin
            issued_next = 1'b0;
        end

        if (cmd.clear_state || cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/wheel_speed_pi_loop.sv
`default_nettype none

// channel   role    payload
// sample    sink    pulse_count[15:0] s, target_speed[20:0] s, clear_history
// result    source  drive_value[16:0] s, drive_clamped
// cfg       sink    index[2:0], data[23:0]; always ready
//
// A control request runs five products through the one shared multiplier,
// each taken as two 12-bit digits of its B operand (gain, wheel correction
// or pulses per rpm), plus filter, error and drive steps.
// A clear request takes only the clear step. Reset clears gains, limits and all three
// state words (wheel correction resets to 1.0). A stalled result holds the
// controller in its last step; the next request is still taken meanwhile.

module wheel_speed_pi_loop #(
    parameter int STATE_WIDTH = 32   // integral, filter and error words, 24..48
) (
    input  logic       clk,
    input  logic       rst_n,
    wspl_in_if.sink    sample,
    wspl_out_if.source result,
    wspl_cfg_if.sink   cfg
);
    import wspl_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // registers take a write every cycle; the user must write only while idle (not enforced)
    assign cfg.ready = 1'b1;

    // sequencer: one state per step, waits on the multiplier and on the
    // result register being free before loading it
    wspl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_clear  (sample.clear_history),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath: config registers, loop state, shared multiplier and the
    // result register
    wspl_dp #(
        .STATE_WIDTH (STATE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_write     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .pulse_count   (sample.pulse_count),
        .target_speed  (sample.target_speed),
        .drive_value   (result.drive_value),
        .drive_clamped (result.drive_clamped)
    );

endmodule

`default_nettype wire

FILE: src/wspl_checker.sv
`default_nettype none

`include "wheel_speed_pi_loop_defines.svh"

module wspl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [16:0] drive_value,
    input logic        drive_clamped
);

    // a stalled result holds
    `WSPL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(drive_value) && $stable(drive_clamped))

    // one request at a time
    `WSPL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // no result appears straight after a request is taken
    `WSPL_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))

    // clamp keeps the drive inside the symmetric 16-bit range
    `WSPL_ASSERT_NOW(a_drive_range, out_valid, drive_value != 17'h10000)

endmodule

bind wheel_speed_pi_loop wspl_checker u_wspl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .drive_value   (result.drive_value),
    .drive_clamped (result.drive_clamped)
);

`default_nettype wire
